FILE: hdl/frpm_pkg.sv
// frpm_pkg: shared widths, reset values, codes and control structs for the
// frame pacer and rate meter. No dependencies; every other file uses it.
`timescale 1ns / 1ps

package frpm_pkg;

  // field and register widths
  localparam int CFG_W     = 10;
  localparam int LEN_W     = 9;
  localparam int ELAPSED_W = 16;
  localparam int SUM_W     = 24;
  localparam int RATE_W    = 18;
  localparam int COUNT_W   = 32;
  // dividend width: largest window (511) times 1000 fits in 19 bits
  localparam int NUM_W     = 19;

  localparam int RING_DEPTH_DEF = 256;
  localparam int MS_PER_S       = 1000;

  // reset values
  localparam logic [CFG_W-1:0]     TICK_PERIOD_RST = CFG_W'(16);
  localparam logic [CFG_W-1:0]     DRAW_PERIOD_RST = CFG_W'(33);
  localparam logic [CFG_W-1:0]     NOMINAL_FPS_RST = CFG_W'(30);
  localparam logic [LEN_W-1:0]     WINDOW_LEN_RST  = LEN_W'(60);
  localparam logic [ELAPSED_W-1:0] RING_RST        = ELAPSED_W'(33);
  localparam logic [SUM_W-1:0]     SUM_RST         = SUM_W'(2000);
  localparam logic [RATE_W-1:0]    RATE_RST        = RATE_W'(30);

  typedef enum logic [1:0] {
    OP_FRAME   = 2'd0,
    OP_TICK    = 2'd1,
    OP_RESTART = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    CFG_TICK_PERIOD = 2'd0,
    CFG_DRAW_PERIOD = 2'd1,
    CFG_NOMINAL_FPS = 2'd2,
    CFG_WINDOW_LEN  = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    DIV_RAW   = 2'd0,
    DIV_PACED = 2'd1,
    DIV_NOM   = 2'd2
  } div_sel_t;

  // controller to datapath
  typedef struct packed {
    logic     latch;       // capture input beat
    logic     sweep_clr;   // restart sweep counter
    logic     clear_wr;    // reset pass write
    logic     fill_wr;     // restart refill write
    logic     rd;          // read ring slot
    logic     frame_upd;   // frame sums, slot, credit
    logic     tick;        // tick request
    logic     restart_ld;  // restart rates and credit
    logic     div_start;
    logic     div_ld;      // take divider result
    div_sel_t div_sel;
    logic     out_load;
  } frpm_cmd_t;

  // datapath to controller
  typedef struct packed {
    op_t  op;
    logic raw_nz;
    logic paced_nz;
    logic clear_last;
    logic fill_last;
    logic div_done;
    logic out_free;
  } frpm_status_t;

endpackage

FILE: hdl/frpm_div.sv
// frpm_div: restoring divider, one quotient bit per cycle.
// Depends on frpm_pkg for operand widths.
`timescale 1ns / 1ps

module frpm_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [frpm_pkg::NUM_W-1:0]  dividend,
  input  logic [frpm_pkg::SUM_W-1:0]  divisor,
  output logic                        done,
  output logic [frpm_pkg::NUM_W-1:0]  quotient
);

  localparam int CNT_W = $clog2(frpm_pkg::NUM_W + 1);

  logic [frpm_pkg::NUM_W-1:0] quo_r;
  logic [frpm_pkg::SUM_W-1:0] rem_r;
  logic [frpm_pkg::SUM_W-1:0] den_r;
  logic [CNT_W-1:0]           cnt_r;
  logic                       busy_r;
  logic                       done_r;
  logic [frpm_pkg::SUM_W:0]   shifted;
  logic [frpm_pkg::SUM_W:0]   diff;

  // trial subtract of the shifted remainder
  assign shifted = {rem_r, quo_r[frpm_pkg::NUM_W-1]};
  assign diff    = shifted - {1'b0, den_r};

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(frpm_pkg::NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // operands and iteration
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      den_r <= divisor;
    end else if (busy_r) begin
      if (!diff[frpm_pkg::SUM_W]) begin
        rem_r <= diff[frpm_pkg::SUM_W-1:0];
        quo_r <= {quo_r[frpm_pkg::NUM_W-2:0], 1'b1};
      end else begin
        rem_r <= shifted[frpm_pkg::SUM_W-1:0];
        quo_r <= {quo_r[frpm_pkg::NUM_W-2:0], 1'b0};
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

FILE: hdl/frpm_dp.sv
// frpm_dp: datapath with configuration registers, the two ring memories,
// sums, rates, tick credit, output register and the shared divider.
// Depends on frpm_pkg and frpm_div.
`timescale 1ns / 1ps

module frpm_dp #(
  parameter int RING_DEPTH = frpm_pkg::RING_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [1:0]                      cfg_index,
  input  logic [frpm_pkg::CFG_W-1:0]      cfg_wdata,
  input  logic [1:0]                      in_op,
  input  logic [frpm_pkg::ELAPSED_W-1:0]  in_raw_elapsed_ms,
  input  logic [frpm_pkg::ELAPSED_W-1:0]  in_paced_elapsed_ms,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic                            out_tick_granted,
  output logic [frpm_pkg::RATE_W-1:0]     out_draw_rate,
  output logic [frpm_pkg::RATE_W-1:0]     out_draw_rate_max,
  output logic [frpm_pkg::COUNT_W-1:0]    out_tick_count,
  input  frpm_pkg::frpm_cmd_t             cmd,
  output frpm_pkg::frpm_status_t          status
);

  localparam int IDX_W = $clog2(RING_DEPTH);
  localparam int DEP_W = $clog2(RING_DEPTH + 1);
  localparam int CMP_W = (DEP_W > frpm_pkg::LEN_W) ? DEP_W : frpm_pkg::LEN_W;
  localparam int EW    = frpm_pkg::ELAPSED_W;
  localparam int SW    = frpm_pkg::SUM_W;
  localparam int RW    = frpm_pkg::RATE_W;
  localparam int CW    = frpm_pkg::COUNT_W;

  // configuration registers
  logic [frpm_pkg::CFG_W-1:0] tick_period_r;
  logic [frpm_pkg::CFG_W-1:0] draw_period_r;
  logic [frpm_pkg::CFG_W-1:0] nominal_fps_r;
  logic [frpm_pkg::LEN_W-1:0] window_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_period_r <= frpm_pkg::TICK_PERIOD_RST;
      draw_period_r <= frpm_pkg::DRAW_PERIOD_RST;
      nominal_fps_r <= frpm_pkg::NOMINAL_FPS_RST;
      window_len_r  <= frpm_pkg::WINDOW_LEN_RST;
    end else if (cfg_we) begin
      case (frpm_pkg::cfg_idx_t'(cfg_index))
        frpm_pkg::CFG_TICK_PERIOD: tick_period_r <= cfg_wdata;
        frpm_pkg::CFG_DRAW_PERIOD: draw_period_r <= cfg_wdata;
        frpm_pkg::CFG_NOMINAL_FPS: nominal_fps_r <= cfg_wdata;
        frpm_pkg::CFG_WINDOW_LEN:  window_len_r  <= cfg_wdata[frpm_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // window length in use: zero as one, clamped to the ring depth
  logic [CMP_W-1:0]           wl_ext;
  logic [CMP_W-1:0]           len_use;
  logic [frpm_pkg::LEN_W-1:0] len_r;
  logic [frpm_pkg::NUM_W-1:0] num_r;

  assign wl_ext = CMP_W'(window_len_r);

  always_comb begin
    if (wl_ext == '0) begin
      len_use = CMP_W'(1);
    end else if (wl_ext > CMP_W'(RING_DEPTH)) begin
      len_use = CMP_W'(RING_DEPTH);
    end else begin
      len_use = wl_ext;
    end
  end

  // latched item
  logic [1:0]  op_r;
  logic [EW-1:0] raw_r;
  logic [EW-1:0] paced_r;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r    <= in_op;
      raw_r   <= in_raw_elapsed_ms;
      paced_r <= in_paced_elapsed_ms;
      len_r   <= frpm_pkg::LEN_W'(len_use);
    end
    num_r <= frpm_pkg::NUM_W'(len_r) * frpm_pkg::NUM_W'(frpm_pkg::MS_PER_S);
  end

  // sweep counter for reset clear and restart refill
  logic [IDX_W-1:0] sweep_r;
  logic             sweep_wr;

  assign sweep_wr = cmd.clear_wr | cmd.fill_wr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r <= '0;
    end else if (cmd.sweep_clr) begin
      sweep_r <= '0;
    end else if (sweep_wr) begin
      sweep_r <= sweep_r + IDX_W'(1);
    end
  end

  // ring memories, one write and one registered read each
  logic [EW-1:0]    raw_ring   [RING_DEPTH];
  logic [EW-1:0]    paced_ring [RING_DEPTH];
  logic [IDX_W-1:0] slot_r;
  logic [IDX_W-1:0] wr_addr;
  logic [EW-1:0]    fill_val;
  logic [EW-1:0]    raw_wdata;
  logic [EW-1:0]    paced_wdata;
  logic             raw_we;
  logic             paced_we;
  logic [EW-1:0]    rd_raw_r;
  logic [EW-1:0]    rd_paced_r;
  logic             raw_nz;
  logic             paced_nz;

  assign raw_nz      = (raw_r != '0);
  assign paced_nz    = (paced_r != '0);
  assign wr_addr     = sweep_wr ? sweep_r : slot_r;
  assign fill_val    = cmd.clear_wr ? frpm_pkg::RING_RST : EW'(draw_period_r);
  assign raw_wdata   = sweep_wr ? fill_val : raw_r;
  assign paced_wdata = sweep_wr ? fill_val : paced_r;
  assign raw_we      = sweep_wr | (cmd.frame_upd & raw_nz);
  assign paced_we    = sweep_wr | (cmd.frame_upd & paced_nz);

  always_ff @(posedge clk) begin
    if (raw_we) begin
      raw_ring[wr_addr] <= raw_wdata;
    end
    if (paced_we) begin
      paced_ring[wr_addr] <= paced_wdata;
    end
    if (cmd.rd) begin
      rd_raw_r   <= raw_ring[slot_r];
      rd_paced_r <= paced_ring[slot_r];
    end
  end

  // sums, rates, credit and tick count registers
  logic [SW-1:0] raw_sum_r;
  logic [SW-1:0] paced_sum_r;
  logic [RW-1:0] rate_now_r;
  logic [RW-1:0] rate_peak_r;
  logic [CW-1:0] credit_r;
  logic [CW-1:0] ticks_r;
  logic          granted_r;

  // slot advance and credit clamp
  logic [CMP_W-1:0] slot_inc;
  logic [IDX_W-1:0] slot_nxt;
  logic [frpm_pkg::CFG_W:0] cap;
  logic [EW-1:0]    credit_add;
  logic [CW:0]      credit_sum;

  assign slot_inc   = CMP_W'(slot_r) + CMP_W'(1);
  assign slot_nxt   = (slot_inc >= CMP_W'(len_r)) ? '0 : slot_r + IDX_W'(1);
  assign cap        = {draw_period_r, 1'b0};
  assign credit_add = (paced_r < EW'(cap)) ? paced_r : EW'(cap);
  assign credit_sum = {1'b0, credit_r} + (CW + 1)'(credit_add);

  // divider operands
  logic [SW-1:0]              den_sel;
  logic [SW-1:0]              den;
  logic                       div_done;
  logic [frpm_pkg::NUM_W-1:0] quo;
  logic [RW-1:0]              quo_sat;

  always_comb begin
    case (cmd.div_sel)
      frpm_pkg::DIV_RAW:   den_sel = raw_sum_r;
      frpm_pkg::DIV_PACED: den_sel = paced_sum_r;
      default:             den_sel = SW'(nominal_fps_r);
    endcase
  end

  assign den     = (den_sel == '0) ? SW'(1) : den_sel;
  assign quo_sat = quo[frpm_pkg::NUM_W-1:RW] != '0 ? '1 : quo[RW-1:0];

  frpm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (num_r),
    .divisor  (den),
    .done     (div_done),
    .quotient (quo)
  );

  // sums, rates, credit and tick count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r      <= '0;
      raw_sum_r   <= frpm_pkg::SUM_RST;
      paced_sum_r <= frpm_pkg::SUM_RST;
      rate_now_r  <= frpm_pkg::RATE_RST;
      rate_peak_r <= frpm_pkg::RATE_RST;
      credit_r    <= CW'(frpm_pkg::TICK_PERIOD_RST);
      ticks_r     <= '0;
      granted_r   <= 1'b0;
    end else begin
      if (cmd.latch) begin
        granted_r <= 1'b0;
      end
      // frame: replace slot contents in the sums, advance, add credit
      if (cmd.frame_upd) begin
        if (raw_nz) begin
          raw_sum_r <= raw_sum_r - SW'(rd_raw_r) + SW'(raw_r);
        end
        if (paced_nz) begin
          paced_sum_r <= paced_sum_r - SW'(rd_paced_r) + SW'(paced_r);
        end
        slot_r   <= slot_nxt;
        credit_r <= credit_sum[CW] ? '1 : credit_sum[CW-1:0];
      end
      // tick: spend one period if present
      if (cmd.tick && (credit_r >= CW'(tick_period_r))) begin
        credit_r  <= credit_r - CW'(tick_period_r);
        ticks_r   <= ticks_r + CW'(1);
        granted_r <= 1'b1;
      end
      // restart: nominal rates, fresh credit
      if (cmd.restart_ld) begin
        rate_now_r  <= RW'(nominal_fps_r);
        rate_peak_r <= RW'(nominal_fps_r);
        credit_r    <= CW'(tick_period_r);
      end
      // divider results
      if (cmd.div_ld) begin
        case (cmd.div_sel)
          frpm_pkg::DIV_RAW:   rate_peak_r <= quo_sat;
          frpm_pkg::DIV_PACED: rate_now_r  <= quo_sat;
          default: begin
            raw_sum_r   <= SW'(quo);
            paced_sum_r <= SW'(quo);
          end
        endcase
      end
    end
  end

  // output register
  logic          out_valid_r;
  logic          out_granted_r;
  logic [RW-1:0] out_rate_r;
  logic [RW-1:0] out_rate_max_r;
  logic [CW-1:0] out_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_granted_r  <= granted_r;
      out_rate_r     <= rate_now_r;
      out_rate_max_r <= rate_peak_r;
      out_count_r    <= ticks_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_tick_granted  = out_granted_r;
  assign out_draw_rate     = out_rate_r;
  assign out_draw_rate_max = out_rate_max_r;
  assign out_tick_count    = out_count_r;

  // status back to the controller
  always_comb begin
    status.op         = frpm_pkg::op_t'(op_r);
    status.raw_nz     = raw_nz;
    status.paced_nz   = paced_nz;
    status.clear_last = (sweep_r == IDX_W'(RING_DEPTH - 1));
    status.fill_last  = ((CMP_W'(sweep_r) + CMP_W'(1)) >= CMP_W'(len_r));
    status.div_done   = div_done;
    status.out_free   = !out_valid_r || out_ready;
  end

endmodule

FILE: hdl/frpm_ctrl.sv
// frpm_ctrl: sequencer for the frame pacer; steps each item through ring
// read, update, divisions and refill. Depends on frpm_pkg.
`timescale 1ns / 1ps

module frpm_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  frpm_pkg::frpm_status_t status,
  output frpm_pkg::frpm_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_FRAME,
    S_DIV_GO,
    S_DIV_WAIT,
    S_FILL,
    S_FINISH
  } state_t;

  state_t               state_r, state_nxt;
  frpm_pkg::div_sel_t   sel_r, sel_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    sel_nxt   = sel_r;
    cmd       = '0;
    cmd.div_sel = sel_r;
    in_ready  = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (status.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        case (status.op)
          frpm_pkg::OP_FRAME: begin
            cmd.rd    = 1'b1;
            state_nxt = S_FRAME;
          end
          frpm_pkg::OP_TICK: begin
            cmd.tick  = 1'b1;
            state_nxt = S_FINISH;
          end
          frpm_pkg::OP_RESTART: begin
            cmd.restart_ld = 1'b1;
            cmd.sweep_clr  = 1'b1;
            sel_nxt        = frpm_pkg::DIV_NOM;
            state_nxt      = S_DIV_GO;
          end
          default: state_nxt = S_FINISH;
        endcase
      end
      S_FRAME: begin
        cmd.frame_upd = 1'b1;
        if (status.raw_nz) begin
          sel_nxt   = frpm_pkg::DIV_RAW;
          state_nxt = S_DIV_GO;
        end else if (status.paced_nz) begin
          sel_nxt   = frpm_pkg::DIV_PACED;
          state_nxt = S_DIV_GO;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (status.div_done) begin
          cmd.div_ld = 1'b1;
          case (sel_r)
            frpm_pkg::DIV_RAW: begin
              if (status.paced_nz) begin
                sel_nxt   = frpm_pkg::DIV_PACED;
                state_nxt = S_DIV_GO;
              end else begin
                state_nxt = S_FINISH;
              end
            end
            frpm_pkg::DIV_PACED: state_nxt = S_FINISH;
            default:             state_nxt = S_FILL;
          endcase
        end
      end
      S_FILL: begin
        cmd.fill_wr = 1'b1;
        if (status.fill_last) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      sel_r   <= frpm_pkg::DIV_NOM;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
    end
  end

endmodule

FILE: hdl/frame_pacer_rate_meter.sv
// frame_pacer_rate_meter: top level joining the sequencer and the datapath.
// Depends on frpm_pkg, frpm_ctrl, frpm_dp (which holds frpm_div).
`timescale 1ns / 1ps

// Frame pacer and rate meter. Each input beat (frame, tick or restart) gives
// exactly one result beat, one item at a time. After reset the block writes
// the reset value into every slot of both rings and takes no input beat
// meanwhile; configuration writes are accepted throughout. Item time is set
// by the single shared restoring divider, which each division starts, steps
// one quotient bit at a time and waits on until done. A tick or unused op is
// decoded and goes to the output load; a frame reads its ring slot, updates
// the sums and runs one division per nonzero elapsed time; a restart runs one
// division and then refills as many ring slots as the window length through
// the one memory write port. A finished result sits in an output register,
// so the next beat is taken while it waits.
module frame_pacer_rate_meter #(
  parameter int RING_DEPTH = frpm_pkg::RING_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [1:0]                      cfg_index,
  input  logic [frpm_pkg::CFG_W-1:0]      cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      in_op,
  input  logic [frpm_pkg::ELAPSED_W-1:0]  in_raw_elapsed_ms,
  input  logic [frpm_pkg::ELAPSED_W-1:0]  in_paced_elapsed_ms,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_tick_granted,
  output logic [frpm_pkg::RATE_W-1:0]     out_draw_rate,
  output logic [frpm_pkg::RATE_W-1:0]     out_draw_rate_max,
  output logic [frpm_pkg::COUNT_W-1:0]    out_tick_count
);

  frpm_pkg::frpm_cmd_t    cmd;
  frpm_pkg::frpm_status_t status;

  frpm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  frpm_dp #(
    .RING_DEPTH (RING_DEPTH)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_op               (in_op),
    .in_raw_elapsed_ms   (in_raw_elapsed_ms),
    .in_paced_elapsed_ms (in_paced_elapsed_ms),
    .out_ready           (out_ready),
    .out_valid           (out_valid),
    .out_tick_granted    (out_tick_granted),
    .out_draw_rate       (out_draw_rate),
    .out_draw_rate_max   (out_draw_rate_max),
    .out_tick_count      (out_tick_count),
    .cmd                 (cmd),
    .status              (status)
  );

  // one item in flight: an accepted beat closes the input side
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in progress");

  // reset starts the ring clearing pass, which blocks input
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input open right after reset");

  // a result only appears when the sequencer hands one over
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.out_load))
    else $error("result beat without a finished item");

  // divider result is only taken when the divider reports done
  a_div_ld_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_ld |-> status.div_done)
    else $error("divider result taken early");

endmodule
